[hw/rtl/ttfd_pkg.sv]
`default_nettype none

package ttfd_pkg;

   // Texel format codes
   localparam logic [3:0] FMT_RGBA8    = 4'd0;
   localparam logic [3:0] FMT_RGB8     = 4'd1;
   localparam logic [3:0] FMT_RGBA5551 = 4'd2;
   localparam logic [3:0] FMT_RGB565   = 4'd3;
   localparam logic [3:0] FMT_RGBA4    = 4'd4;
   localparam logic [3:0] FMT_IA8      = 4'd5;
   localparam logic [3:0] FMT_RG8      = 4'd6;
   localparam logic [3:0] FMT_I8       = 4'd7;
   localparam logic [3:0] FMT_A8       = 4'd8;
   localparam logic [3:0] FMT_IA4      = 4'd9;
   localparam logic [3:0] FMT_I4       = 4'd10;
   localparam logic [3:0] FMT_A4       = 4'd11;

   // Configuration register indexes
   localparam logic CSR_TEXTURE_WIDTH = 1'b0;
   localparam logic CSR_TEXEL_FORMAT  = 1'b1;

   localparam int WIDTH_W = 11;   // texture_width register
   localparam int FMT_W   = 4;    // texel_format register
   localparam int COORD_W = 10;
   localparam int IDX_W   = 20;   // texel index, largest tile base plus in-tile offset
   localparam int OFF_W   = 23;   // byte offset plus bytes per texel

   typedef struct packed {
      logic [FMT_W-1:0] fmt;
      logic             u_odd;
   } unpack_ctl_type;

   // Bytes read per texel; zero marks a format with no decode
   function automatic logic [2:0] texel_bytes(input logic [FMT_W-1:0] fmt);
      logic [2:0] n;
      unique case (fmt)
         FMT_RGBA8:                                         n = 3'd4;
         FMT_RGB8:                                          n = 3'd3;
         FMT_RGBA5551, FMT_RGB565, FMT_RGBA4, FMT_IA8, FMT_RG8: n = 3'd2;
         FMT_I8, FMT_A8, FMT_IA4, FMT_I4, FMT_A4:           n = 3'd1;
         default:                                           n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/ttfd_store.sv]
`default_nettype none

module ttfd_store #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/ttfd_unpack.sv]
`default_nettype none

module ttfd_unpack (
   input  wire ttfd_pkg::unpack_ctl_type ctl,
   input  wire logic [31:0]              bytes,   // byte 0 in the lowest bits
   output      logic [31:0]              colour
);

   function automatic logic [7:0] widen4(input logic [3:0] x);
      return {x, x};
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] x);
      return {x, x[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] x);
      return {x, x[5:4]};
   endfunction

   logic [7:0]  b0, b1, b2, b3;
   logic [15:0] t;
   logic [3:0]  nib;

   assign b0  = bytes[7:0];
   assign b1  = bytes[15:8];
   assign b2  = bytes[23:16];
   assign b3  = bytes[31:24];
   assign t   = {b1, b0};
   assign nib = ctl.u_odd ? b0[7:4] : b0[3:0];

   always_comb begin
      unique case (ctl.fmt)
         ttfd_pkg::FMT_RGBA8:    colour = {b0, b1, b2, b3};
         ttfd_pkg::FMT_RGB8:     colour = {8'hff, b0, b1, b2};
         ttfd_pkg::FMT_RGBA5551: colour = {{8{t[0]}}, widen5(t[5:1]), widen5(t[10:6]),
                                           widen5(t[15:11])};
         ttfd_pkg::FMT_RGB565:   colour = {8'hff, widen5(t[4:0]), widen6(t[10:5]),
                                           widen5(t[15:11])};
         ttfd_pkg::FMT_RGBA4:    colour = {widen4(t[3:0]), widen4(t[7:4]), widen4(t[11:8]),
                                           widen4(t[15:12])};
         ttfd_pkg::FMT_IA8:      colour = {b0, b1, b1, b1};
         ttfd_pkg::FMT_RG8:      colour = {8'hff, 8'h00, b0, b1};
         ttfd_pkg::FMT_I8:       colour = {8'hff, b0, b0, b0};
         ttfd_pkg::FMT_A8:       colour = {b0, 24'h000000};
         ttfd_pkg::FMT_IA4:      colour = {widen4(b0[3:0]), widen4(b0[7:4]), widen4(b0[7:4]),
                                           widen4(b0[7:4])};
         ttfd_pkg::FMT_I4:       colour = {8'hff, widen4(nib), widen4(nib), widen4(nib)};
         ttfd_pkg::FMT_A4:       colour = {widen4(nib), 24'h000000};
         default:                colour = 32'h0000_0000;
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/tiled_texel_fetch_decode.sv]
// Channel   Ports                       Moves
// req       req_tvalid/tready/tdata/tuser  store write or sample request
// rsp       rsp_tvalid/tready/tdata/tuser  decoded colour and range flag
// csr       csr_we/index/wdata             texture width and texel format
//
// A store write leaves the sequencer idle. A sample runs MUL, IDX, SCALE, END, a READ
// per byte (n = 1 to 4 bytes per texel), WAIT and OUT, through one shared adder and one
// store read port; out of range it skips from END to OUT, an unknown format from IDLE.
// req_tready is high only while the sequencer is idle; a waiting response does not stop
// store writes, and a finished sample holds until the response register is free.
// Reset (synchronous) clears the sequencer and the response valid; the store needs none.
`default_nettype none

module tiled_texel_fetch_decode #(
   parameter int STORE_BYTES = 65536,
   parameter int MAX_WIDTH   = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,   // write_address, write_byte, u_coord, v_coord, zero pad
   input  wire logic        req_tuser,   // func

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // colour
   output      logic        rsp_tuser,   // out_of_range

   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [10:0] csr_wdata
);

   localparam int AW    = $clog2(STORE_BYTES);
   localparam int OFF_W = ttfd_pkg::OFF_W;
   localparam int IDX_W = ttfd_pkg::IDX_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_IDX   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_WAIT  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   // Configuration
   logic [ttfd_pkg::WIDTH_W-1:0] width_ff, width_in, width_eff;
   logic [ttfd_pkg::FMT_W-1:0]   fmt_ff, fmt_in;

   always_comb begin
      width_in = width_ff;
      fmt_in   = fmt_ff;
      if (csr_we) begin
         unique case (csr_index)
            ttfd_pkg::CSR_TEXTURE_WIDTH: width_in = csr_wdata;
            ttfd_pkg::CSR_TEXEL_FORMAT:  fmt_in   = csr_wdata[ttfd_pkg::FMT_W-1:0];
            default:                     width_in = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= ttfd_pkg::WIDTH_W'(8);
         fmt_ff   <= ttfd_pkg::FMT_RGBA8;
      end else begin
         width_ff <= width_in;
         fmt_ff   <= fmt_in;
      end
   end

   assign width_eff = (width_ff > ttfd_pkg::WIDTH_W'(MAX_WIDTH)) ?
                      ttfd_pkg::WIDTH_W'(MAX_WIDTH) : width_ff;

   // Request fields
   logic [15:0]                  in_waddr;
   logic [7:0]                   in_wbyte;
   logic [ttfd_pkg::COORD_W-1:0] in_u, in_v;
   logic                         req_acc, wr_hit;
   logic [OFF_W-1:0]             waddr_ext;
   logic [2:0]                   nbytes;

   assign in_waddr  = req_tdata[15:0];
   assign in_wbyte  = req_tdata[23:16];
   assign in_u      = req_tdata[33:24];
   assign in_v      = req_tdata[43:34];
   assign req_acc   = req_tvalid && req_tready;
   assign waddr_ext = OFF_W'(in_waddr);
   assign wr_hit    = req_acc && !req_tuser && (waddr_ext < OFF_W'(STORE_BYTES));
   assign nbytes    = ttfd_pkg::texel_bytes(fmt_ff);

   // Sequencer and datapath registers
   logic [2:0]                   state_ff, state_in;
   logic [ttfd_pkg::COORD_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [17:0]                  prod_ff, prod_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [OFF_W-1:0]             off_ff, off_in;
   logic [1:0]                   rd_cnt_ff, rd_cnt_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [1:0]                   rd_slot_ff, rd_slot_in;
   logic                         zero_ff, zero_in;
   logic                         oor_ff, oor_in;
   logic [7:0]                   bytes_ff [4];

   // Shared adder
   logic [OFF_W-1:0] op_a, op_b, sum;
   logic [5:0]       morton;
   logic [OFF_W-1:0] idx_ext;

   assign morton  = {v_ff[2], u_ff[2], v_ff[1], u_ff[1], v_ff[0], u_ff[0]};
   assign idx_ext = OFF_W'(idx_ff);

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_IDX: begin
            op_a = OFF_W'({prod_ff, 3'b000});
            op_b = OFF_W'({u_ff[ttfd_pkg::COORD_W-1:3], morton});
         end
         ST_SCALE: begin
            priority case (nbytes)
               3'd4:    op_a = idx_ext << 2;
               3'd3: begin
                  op_a = idx_ext;
                  op_b = idx_ext << 1;
               end
               3'd2:    op_a = idx_ext << 1;
               default: op_a = (fmt_ff == ttfd_pkg::FMT_I4 || fmt_ff == ttfd_pkg::FMT_A4) ?
                               (idx_ext >> 1) : idx_ext;
            endcase
         end
         ST_END: begin
            op_a = off_ff;
            op_b = OFF_W'(nbytes);
         end
         ST_READ: begin
            op_a = off_ff;
            op_b = OFF_W'(rd_cnt_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign sum = op_a + op_b;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_oor_ff, rsp_oor_in;
   logic        out_load;
   logic [31:0] colour;

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      prod_in    = prod_ff;
      idx_in     = idx_ff;
      off_in     = off_ff;
      rd_cnt_in  = rd_cnt_ff;
      rd_pend_in = 1'b0;
      rd_slot_in = rd_cnt_ff;
      zero_in    = zero_ff;
      oor_in     = oor_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser) begin
               u_in    = in_u;
               v_in    = in_v;
               oor_in  = 1'b0;
               zero_in = (nbytes == 3'd0);
               state_in = (nbytes == 3'd0) ? ST_OUT : ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 18'(v_ff[ttfd_pkg::COORD_W-1:3]) * 18'(width_eff);
            state_in = ST_IDX;
         end
         ST_IDX: begin
            idx_in   = sum[IDX_W-1:0];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            off_in    = sum;
            rd_cnt_in = '0;
            state_in  = ST_END;
         end
         ST_END: begin
            if (sum > OFF_W'(STORE_BYTES)) begin
               zero_in  = 1'b1;
               oor_in   = 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_pend_in = 1'b1;
            rd_cnt_in  = rd_cnt_ff + 2'd1;
            if (OFF_W'(rd_cnt_ff) == OFF_W'(nbytes) - OFF_W'(1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      v_ff       <= v_in;
      prod_ff    <= prod_in;
      idx_ff     <= idx_in;
      off_ff     <= off_in;
      rd_cnt_ff  <= rd_cnt_in;
      rd_slot_ff <= rd_slot_in;
      zero_ff    <= zero_in;
      oor_ff     <= oor_in;
   end

   // Texture store
   logic [7:0] rd_data;

   ttfd_store #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_hit),
      .wr_addr (waddr_ext[AW-1:0]),
      .wr_data (in_wbyte),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (sum[AW-1:0]),
      .rd_data (rd_data)
   );

   // Land each read byte in its slot in the cycle after its issue
   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         bytes_ff[rd_slot_ff] <= rd_data;
      end
   end

   // Format expansion
   ttfd_pkg::unpack_ctl_type unpack_ctl;

   assign unpack_ctl.fmt   = fmt_ff;
   assign unpack_ctl.u_odd = u_ff[0];

   ttfd_unpack u_unpack (
      .ctl    (unpack_ctl),
      .bytes  ({bytes_ff[3], bytes_ff[2], bytes_ff[1], bytes_ff[0]}),
      .colour (colour)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = zero_ff ? 32'h0000_0000 : colour;
         rsp_oor_in   = oor_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_oor_ff;

`ifndef SYNTHESIS
   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> state_ff == ST_IDLE)
      else $error("store write item left the sequencer idle state");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> sum < OFF_W'(STORE_BYTES))
      else $error("store read issued beyond the store");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> OFF_W'(rd_cnt_ff) < OFF_W'(nbytes))
      else $error("more store reads than bytes per texel");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'h0000_0000)
      else $error("out-of-range response carries a colour");
`endif

endmodule

`default_nettype wire

[tb/tb_tiled_texel_fetch_decode.sv]
module tb_tiled_texel_fetch_decode;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   STORE_SIZE   = 65536;
   localparam int   MAX_TEX_W    = 1024;
   localparam int   MAX_REPORTS  = 10;
   localparam int   SETTLE_TICKS = 16;
   localparam int   RANDOM_ITEMS = 1450;
   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_SAMPLE  = 1'b1;

   typedef struct packed {
      logic [31:0] colour;
      logic        out_of_range;
   } texel_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [10:0] csr_wdata  = '0;

   // Shadow of the texture store and the registers
   logic [7:0]  store_copy [STORE_SIZE];
   bit          written    [STORE_SIZE];
   logic [10:0] cur_width  = 11'd8;
   logic [3:0]  cur_format = ttfd_pkg::FMT_RGBA8;

   texel_result_type expected_texels[$];
   int mismatches = 0;
   int items_sent = 0;
   int ready_hold = 0;
   int stall_pct  = 20;
   bit quiet_req  = 1'b0;

   tiled_texel_fetch_decode dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int idle_gap(input bit none);
      int r;
      r = $urandom_range(0, 99);
      if (none || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] widen4(input logic [3:0] x);
      return {x, x};
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] x);
      return {x, x[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] x);
      return {x, x[5:4]};
   endfunction

   // Tile base plus Morton offset, scaled to bytes; nbytes 0 marks an unknown format
   function automatic longint texel_byte_offset(input logic [9:0] u, input logic [9:0] v,
                                                output int nbytes);
      longint w;
      longint index;
      w = (cur_width > MAX_TEX_W) ? MAX_TEX_W : cur_width;
      index = longint'({u[9:3], 3'b000}) * 8 + longint'({v[9:3], 3'b000}) * w
            + longint'({v[2], u[2], v[1], u[1], v[0], u[0]});
      case (cur_format)
         ttfd_pkg::FMT_RGBA8: begin
            nbytes = 4;
            return index * 4;
         end
         ttfd_pkg::FMT_RGB8: begin
            nbytes = 3;
            return index * 3;
         end
         ttfd_pkg::FMT_RGBA5551, ttfd_pkg::FMT_RGB565, ttfd_pkg::FMT_RGBA4,
         ttfd_pkg::FMT_IA8, ttfd_pkg::FMT_RG8: begin
            nbytes = 2;
            return index * 2;
         end
         ttfd_pkg::FMT_I8, ttfd_pkg::FMT_A8, ttfd_pkg::FMT_IA4: begin
            nbytes = 1;
            return index;
         end
         ttfd_pkg::FMT_I4, ttfd_pkg::FMT_A4: begin
            nbytes = 1;
            return index >> 1;
         end
         default: begin
            nbytes = 0;
            return 0;
         end
      endcase
   endfunction

   function automatic texel_result_type predict_texel(input logic [9:0] u,
                                                      input logic [9:0] v);
      texel_result_type r;
      longint           off;
      int               n;
      logic [7:0]       b [4];
      logic [15:0]      h;
      logic [3:0]       nib;
      r   = '0;
      off = texel_byte_offset(u, v, n);
      if (n == 0) return r;
      if (off + n > STORE_SIZE) begin
         r.out_of_range = 1'b1;
         return r;
      end
      for (int k = 0; k < 4; k++)
         b[k] = (k < n) ? store_copy[off + k] : 8'h00;
      h   = {b[1], b[0]};
      nib = u[0] ? b[0][7:4] : b[0][3:0];
      case (cur_format)
         ttfd_pkg::FMT_RGBA8:    r.colour = {b[0], b[1], b[2], b[3]};
         ttfd_pkg::FMT_RGB8:     r.colour = {8'hFF, b[0], b[1], b[2]};
         ttfd_pkg::FMT_RGBA5551: r.colour = {{8{h[0]}}, widen5(h[5:1]), widen5(h[10:6]),
                                             widen5(h[15:11])};
         ttfd_pkg::FMT_RGB565:   r.colour = {8'hFF, widen5(h[4:0]), widen6(h[10:5]),
                                             widen5(h[15:11])};
         ttfd_pkg::FMT_RGBA4:    r.colour = {widen4(h[3:0]), widen4(h[7:4]), widen4(h[11:8]),
                                             widen4(h[15:12])};
         ttfd_pkg::FMT_IA8:      r.colour = {b[0], b[1], b[1], b[1]};
         ttfd_pkg::FMT_RG8:      r.colour = {8'hFF, 8'h00, b[0], b[1]};
         ttfd_pkg::FMT_I8:       r.colour = {8'hFF, b[0], b[0], b[0]};
         ttfd_pkg::FMT_A8:       r.colour = {b[0], 24'h000000};
         ttfd_pkg::FMT_IA4:      r.colour = {widen4(b[0][3:0]), {3{widen4(b[0][7:4])}}};
         ttfd_pkg::FMT_I4:       r.colour = {8'hFF, {3{widen4(nib)}}};
         ttfd_pkg::FMT_A4:       r.colour = {widen4(nib), 24'h000000};
         default:                r.colour = '0;
      endcase
      return r;
   endfunction

   task automatic send_item(input logic func, input logic [15:0] addr, input logic [7:0] data,
                            input logic [9:0] u, input logic [9:0] v);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {4'h0, v, u, data, addr};
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_WRITE) begin
         store_copy[addr] = data;
         written[addr]    = 1'b1;
      end else begin
         expected_texels = {expected_texels, predict_texel(u, v)};
      end
      items_sent++;
      gap = idle_gap(quiet_req);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_byte_item(input logic [15:0] addr, input logic [7:0] data);
      send_item(FUNC_WRITE, addr, data, 10'($urandom), 10'($urandom));
   endtask

   // Fill any store byte the texel needs that was never written, refresh a few others
   task automatic sample_texel(input logic [9:0] u, input logic [9:0] v);
      longint off;
      int     n;
      off = texel_byte_offset(u, v, n);
      if (n > 0 && off + n <= STORE_SIZE)
         for (int k = 0; k < n; k++)
            if (!written[off + k] || $urandom_range(0, 3) == 0)
               write_byte_item(16'(off + k), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'($urandom), 8'($urandom), u, v);
   endtask

   task automatic wait_idle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (expected_texels.size() != 0) @(posedge clock);
      // a trailing store write gives no result, so let it settle
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [10:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == ttfd_pkg::CSR_TEXTURE_WIDTH) cur_width = val;
      else cur_format = val[3:0];
   endtask

   task automatic configure(input logic [10:0] width, input logic [10:0] fmt_word);
      wait_idle();
      write_csr(ttfd_pkg::CSR_TEXTURE_WIDTH, width);
      write_csr(ttfd_pkg::CSR_TEXEL_FORMAT, fmt_word);
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      sample_texel(10'd0, 10'd0);
      sample_texel(10'd1023, 10'd1023);
   endtask

   task automatic test_store_extremes();
      write_byte_item(16'h0000, 8'hFF);
      write_byte_item(16'hFFFF, 8'hFF);
      write_byte_item(16'h0001, 8'h00);
      // texel (15, 1023) at width 16 ends on the last byte of the store
      configure(11'd16, 11'(ttfd_pkg::FMT_RGBA8));
      sample_texel(10'd15, 10'd1023);
      sample_texel(10'd16, 10'd1023);
      configure(11'd1024, 11'(ttfd_pkg::FMT_RGBA8));
      sample_texel(10'd0, 10'd1023);
   endtask

   task automatic test_width_clamp();
      configure(11'd2047, 11'(ttfd_pkg::FMT_I8));
      sample_texel(10'd9, 10'd8);
      configure(11'd13, 11'(ttfd_pkg::FMT_I8));
      sample_texel(10'd7, 10'd9);
   endtask

   task automatic test_every_format();
      for (int f = 0; f < 16; f++) begin
         configure(11'd8, 11'(f));
         sample_texel(10'(f), 10'(15 - f));
      end
      sample_texel(10'd3, 10'd0);
   endtask

   task automatic test_random_phases();
      int           first;
      logic [10:0]  width;
      logic [10:0]  fmt_word;
      logic [9:0]   u;
      logic [9:0]   v;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       width = 11'd8;
            1:       width = 11'd1024;
            2:       width = 11'($urandom);
            3:       width = 11'($urandom_range(1, 128) * 8);
            4:       width = 11'd2047;
            default: width = 11'd16;
         endcase
         fmt_word = 11'($urandom_range(0, 15));
         if ($urandom_range(0, 3) == 0) fmt_word[10:4] = 7'($urandom);
         configure(width, fmt_word);
         quiet_req = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            default: stall_pct = 60;
         endcase
         repeat ($urandom_range(40, 120)) begin
            if (items_sent - first >= RANDOM_ITEMS) break;
            if ($urandom_range(0, 99) < 15) begin
               write_byte_item(16'($urandom), 8'($urandom));
            end else begin
               u = 10'($urandom);
               // keep most rows low so wide textures still land inside the store
               v = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
               sample_texel(u, v);
            end
         end
      end
      quiet_req = 1'b0;
   endtask

   always @(posedge clock) begin
      texel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_texels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected texel: colour %h range %b", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_texels.pop_front();
            if (rsp_tdata !== want.colour || rsp_tuser !== want.out_of_range) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("texel wrong: colour exp %h got %h, range exp %b got %b",
                           want.colour, rsp_tdata, want.out_of_range, rsp_tuser);
            end
         end
      end
      if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < stall_pct) ready_hold = idle_gap(1'b0);
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_store_extremes();
      test_width_clamp();
      test_every_format();
      test_random_phases();
      wait_idle();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
